// ===== src/assert_macros.svh =====
// Assertion macros shared by the frame receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, off while rst is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/brx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the binary frame receiver
package brx_pkg;

  // Frame format
  localparam logic [7:0] HDR_BYTE0   = 8'hA5;
  localparam logic [7:0] HDR_BYTE1   = 8'h5A;
  localparam logic [7:0] HDR_BYTE2   = 8'h80;
  localparam logic [7:0] FOOTER_BYTE = 8'h04;
  localparam int unsigned LEN_MAX    = 80;

  // Defaults for the top-level parameters
  localparam int unsigned STORE_DEPTH_DEF = 48;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Width of run lengths, payload positions and frame lengths
  localparam int unsigned CNT_W = 7;

  // Configuration port
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam logic [APB_ADDR_W-3:0] REG_COPY_LIMIT = 1'b0;
  localparam logic [7:0] COPY_LIMIT_RST = 8'hFF;

  // Deframer states
  typedef enum logic [2:0] {
    ST_HDR0,
    ST_HDR1,
    ST_HDR2,
    ST_LEN,
    ST_PAY,
    ST_CSUM,
    ST_FOOT
  } front_state_t;

  // Run descriptor handed from front to back
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } run_push_t;

  // Queue status
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

// ===== src/brx_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data
module brx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = brx_pkg::STORE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/brx_front.sv =====
`timescale 1ns / 1ps
// Deframer: header search, length, payload store, checksum and footer check
`include "assert_macros.svh"
module brx_front #(
  parameter int unsigned STORE_DEPTH = brx_pkg::STORE_DEPTH_DEF,
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           rx_byte,
  input  logic                 overrun,
  input  logic [7:0]           copy_limit,
  input  logic                 back_busy,
  input  brx_pkg::queue_stat_t q_stat,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  output brx_pkg::run_push_t   push
);

  brx_pkg::front_state_t state, state_next;
  logic [brx_pkg::CNT_W-1:0] frame_length;
  logic [brx_pkg::CNT_W-1:0] pay_idx;
  logic [brx_pkg::CNT_W-1:0] pay_idx_inc;
  logic [7:0]                checksum;
  logic                      take;
  logic                      len_ok;
  logic [7:0]                run_len;
  logic [7:0]                run_clamp;

  assign take        = in_valid && in_ready && !overrun;
  assign pay_idx_inc = pay_idx + brx_pkg::CNT_W'(1);
  assign len_ok      = (rx_byte != 8'h00) && (rx_byte <= 8'(brx_pkg::LEN_MAX));

  // Clamp the run to the copy limit and the store depth
  always_comb begin
    run_len   = (8'(frame_length) < copy_limit) ? 8'(frame_length) : copy_limit;
    run_clamp = (run_len < 8'(STORE_DEPTH)) ? run_len : 8'(STORE_DEPTH);
  end

  // Next state
  always_comb begin
    state_next = state;
    if (take) begin
      case (state)
        brx_pkg::ST_HDR0:
          state_next = (rx_byte == brx_pkg::HDR_BYTE0) ? brx_pkg::ST_HDR1 : brx_pkg::ST_HDR0;
        brx_pkg::ST_HDR1:
          state_next = (rx_byte == brx_pkg::HDR_BYTE1) ? brx_pkg::ST_HDR2 : brx_pkg::ST_HDR0;
        brx_pkg::ST_HDR2:
          state_next = (rx_byte == brx_pkg::HDR_BYTE2) ? brx_pkg::ST_LEN : brx_pkg::ST_HDR0;
        brx_pkg::ST_LEN:
          state_next = len_ok ? brx_pkg::ST_PAY : brx_pkg::ST_HDR0;
        brx_pkg::ST_PAY:
          state_next = (pay_idx_inc >= frame_length) ? brx_pkg::ST_CSUM : brx_pkg::ST_PAY;
        brx_pkg::ST_CSUM:
          state_next = (rx_byte == checksum) ? brx_pkg::ST_FOOT : brx_pkg::ST_HDR0;
        brx_pkg::ST_FOOT:
          state_next = brx_pkg::ST_HDR0;
        default:
          state_next = brx_pkg::ST_HDR0;
      endcase
    end
  end

  // Outputs: stall payload while the store drains and footer while the queue is full, write store, push run
  always_comb begin
    in_ready   = 1'b1;
    wr_en      = 1'b0;
    push.valid = 1'b0;
    push.count = brx_pkg::CNT_W'(run_clamp);
    case (state)
      brx_pkg::ST_PAY: begin
        in_ready = !back_busy;
        wr_en    = take && (pay_idx < brx_pkg::CNT_W'(STORE_DEPTH));
      end
      brx_pkg::ST_FOOT: begin
        in_ready   = !q_stat.full;
        push.valid = take && (rx_byte == brx_pkg::FOOTER_BYTE);
      end
      default: begin
        in_ready = 1'b1;
      end
    endcase
  end

  assign wr_addr = pay_idx[AW-1:0];
  assign wr_data = rx_byte;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brx_pkg::ST_HDR0;
    end else begin
      state <= state_next;
    end
  end

  // Length, position and checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= '0;
      pay_idx      <= '0;
      checksum     <= '0;
    end else if (take) begin
      if (state == brx_pkg::ST_LEN && len_ok) begin
        frame_length <= rx_byte[brx_pkg::CNT_W-1:0];
        pay_idx      <= '0;
        checksum     <= '0;
      end else if (state == brx_pkg::ST_PAY) begin
        pay_idx  <= pay_idx_inc;
        checksum <= checksum ^ rx_byte;
      end
    end
  end

  `ASSERT_CLK(a_no_write_busy, wr_en |-> !back_busy, "store written while run drains")
  `ASSERT_CLK(a_idx_in_frame, (state == brx_pkg::ST_PAY) |-> (pay_idx < frame_length),
              "payload position past frame length")
  `ASSERT_NEXT(a_push_to_hdr, push.valid, state == brx_pkg::ST_HDR0,
               "deframer not back in header search after a run")

endmodule

// ===== src/brx_queue.sv =====
`timescale 1ns / 1ps
// Short queue of run descriptors between deframer and run emitter
`include "assert_macros.svh"
module brx_queue #(
  parameter int unsigned DEPTH = brx_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  brx_pkg::run_push_t               push,
  input  logic                             pop,
  output logic [brx_pkg::CNT_W-1:0]        head,
  output brx_pkg::queue_stat_t             stat
);

  logic [brx_pkg::CNT_W-1:0] entries [DEPTH];
  logic [PW-1:0]             wr_ptr;
  logic [PW-1:0]             rd_ptr;
  logic [CW-1:0]             count;
  logic                      do_push;
  logic                      do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  // Store pushed descriptor
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.count;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  `ASSERT_CLK(a_count_range, count <= CW'(DEPTH), "queue count out of range")
  `ASSERT_CLK(a_no_overflow, push.valid |-> !stat.full, "descriptor pushed into full queue")

endmodule

// ===== src/brx_back.sv =====
`timescale 1ns / 1ps
// Run emitter: reads the stored payload and drives the output words
`include "assert_macros.svh"
module brx_back #(
  parameter int unsigned STORE_DEPTH = brx_pkg::STORE_DEPTH_DEF,
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  brx_pkg::queue_stat_t      q_stat,
  input  logic [brx_pkg::CNT_W-1:0] q_head,
  output logic                      pop,
  output logic                      busy,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic [7:0]                rd_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                payload_byte,
  output logic [5:0]                byte_index,
  output logic [5:0]                copy_count,
  output logic                      has_data,
  output logic                      last
);

  logic                      active;
  logic [brx_pkg::CNT_W-1:0] k;
  logic [brx_pkg::CNT_W-1:0] k_inc;
  logic [brx_pkg::CNT_W-1:0] n;
  logic                      advance;

  assign advance      = !out_valid || out_ready;
  assign k_inc        = k + brx_pkg::CNT_W'(1);
  assign pop          = advance && !active && !q_stat.empty;
  assign rd_en        = advance && active;
  assign rd_addr      = k[AW-1:0];
  assign busy         = active || !q_stat.empty;
  assign payload_byte = has_data ? rd_data : 8'h00;

  // Step through the run, one word per free output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
      n         <= '0;
    end else if (advance) begin
      if (active) begin
        out_valid <= 1'b1;
        k         <= k_inc;
        active    <= (k_inc != n);
      end else if (!q_stat.empty) begin
        n         <= q_head;
        k         <= '0;
        active    <= (q_head != '0);
        out_valid <= (q_head == '0);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word fields
  always_ff @(posedge clk) begin
    if (advance) begin
      if (active) begin
        byte_index <= k[5:0];
        copy_count <= n[5:0];
        has_data   <= 1'b1;
        last       <= (k_inc == n);
      end else begin
        byte_index <= '0;
        copy_count <= '0;
        has_data   <= 1'b0;
        last       <= 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_marker_shape, (out_valid && !has_data) |-> (last && byte_index == 6'd0
              && copy_count == 6'd0), "empty-run marker malformed")
  `ASSERT_CLK(a_last_position, (out_valid && has_data && last) |->
              (6'(byte_index + 6'd1) == copy_count), "last word not at end of run")
  `ASSERT_CLK(a_read_in_store, rd_en |-> (k < brx_pkg::CNT_W'(STORE_DEPTH)),
              "store read beyond depth")

endmodule

// ===== src/binary_frame_receiver.sv =====
`timescale 1ns / 1ps
// Top level of the binary frame receiver: config register, deframer, queue, emitter
//
//   channel  | role      | signals                             | word
//   ---------+-----------+-------------------------------------+------------------------------
//   s_*      | bytes in  | s_tvalid s_tready s_tdata s_tuser   | rx byte, overrun flag
//   m_*      | runs out  | m_tvalid m_tready m_tdata m_tuser   | payload byte, index, count,
//            |           | m_tlast                             | has-data flag, end of run
//   apb      | config    | psel penable pwrite paddr pwdata    | copy_limit at address 0
//            |           | prdata pready                       |
//
// Payload words stall while a previous run still drains from the payload store, since the
// single store RAM serves both sides. A run's descriptor is pushed into the queue with its
// footer word and popped into the emitter, whose registered output then gives one word per
// cycle while m_tready is high.
// Reset clears control state and sets copy_limit to 255; the store RAM is not cleared.
module binary_frame_receiver #(
  parameter int unsigned STORE_DEPTH = brx_pkg::STORE_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = brx_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
  input  logic                            s_tuser,   // [0] overrun
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // [7:0] payload_byte, [13:8] byte_index,
                                                     // [19:14] copy_count, [23:20] zero
  output logic                            m_tuser,   // [0] has_data
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brx_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [brx_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [brx_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic [7:0]                copy_limit;
  logic                      reg_hit;
  brx_pkg::run_push_t        push;
  brx_pkg::queue_stat_t      q_stat;
  logic [brx_pkg::CNT_W-1:0] q_head;
  logic                      pop;
  logic                      back_busy;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [7:0]                wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [7:0]                rd_data;
  logic [7:0]                payload_byte;
  logic [5:0]                byte_index;
  logic [5:0]                copy_count;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[brx_pkg::APB_ADDR_W-1:2] == brx_pkg::REG_COPY_LIMIT);
  assign prdata  = reg_hit ? {{(brx_pkg::APB_DATA_W - 8){1'b0}}, copy_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      copy_limit <= brx_pkg::COPY_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      copy_limit <= pwdata[7:0];
    end
  end

  brx_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .rx_byte    (s_tdata),
    .overrun    (s_tuser),
    .copy_limit (copy_limit),
    .back_busy  (back_busy),
    .q_stat     (q_stat),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .push       (push)
  );

  brx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (q_head),
    .stat (q_stat)
  );

  brx_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  brx_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_head       (q_head),
    .pop          (pop),
    .busy         (back_busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .copy_count   (copy_count),
    .has_data     (m_tuser),
    .last         (m_tlast)
  );

  // Pack the output word
  assign m_tdata = {4'b0000, copy_count, byte_index, payload_byte};

endmodule
